FILE: hdl/lht_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lht_pkg: shared types and codes for the linear hash table
// Request kinds, result codes, controller operation codes and the
// command/status structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package lht_pkg;

  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;
  localparam int KEY_W    = 64;
  localparam int DATA_W   = 64;
  localparam int LL_W     = 4;

  localparam logic [LL_W-1:0] LL_RESET = 4'd5;

  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_CLEAR     = 5'd0;
  localparam logic [OP_W-1:0] OP_IDLE      = 5'd1;
  localparam logic [OP_W-1:0] OP_DISPATCH  = 5'd2;
  localparam logic [OP_W-1:0] OP_HEAD      = 5'd3;
  localparam logic [OP_W-1:0] OP_HEADW     = 5'd4;
  localparam logic [OP_W-1:0] OP_LK_RD     = 5'd5;
  localparam logic [OP_W-1:0] OP_LK_CMP    = 5'd6;
  localparam logic [OP_W-1:0] OP_INS       = 5'd7;
  localparam logic [OP_W-1:0] OP_SP_START  = 5'd8;
  localparam logic [OP_W-1:0] OP_SP_HEADW  = 5'd9;
  localparam logic [OP_W-1:0] OP_SP_RD     = 5'd10;
  localparam logic [OP_W-1:0] OP_SP_CMP    = 5'd11;
  localparam logic [OP_W-1:0] OP_SP_WR_OLD = 5'd12;
  localparam logic [OP_W-1:0] OP_SP_WR_NEW = 5'd13;
  localparam logic [OP_W-1:0] OP_ALLOC     = 5'd14;
  localparam logic [OP_W-1:0] OP_ALLOC_W   = 5'd15;
  localparam logic [OP_W-1:0] OP_INS_HEAD  = 5'd16;
  localparam logic [OP_W-1:0] OP_INS_LINK  = 5'd17;
  localparam logic [OP_W-1:0] OP_RM_RD     = 5'd18;
  localparam logic [OP_W-1:0] OP_RM_CMP    = 5'd19;
  localparam logic [OP_W-1:0] OP_RM_FREE   = 5'd20;
  localparam logic [OP_W-1:0] OP_FIN       = 5'd21;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            in_acc;
    logic            out_load;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              cur_nil;
    logic              lk_hit;
    logic              rm_hit;
    logic              pool_full;
    logic              split_go;
    logic              free_avail;
    logic              clr_done;
  } sts_t;

endpackage
`default_nettype wire

FILE: hdl/lht_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lht_if: request, response and configuration channels
// Valid/ready channels with source and sink modports.
// ----------------------------------------------------------------------------
interface lht_req_if;
  logic                       valid;
  logic                       ready;
  logic [lht_pkg::KIND_W-1:0] kind;
  logic [lht_pkg::KEY_W-1:0]  key;
  logic [lht_pkg::DATA_W-1:0] data;
  modport source (output valid, output kind, output key, output data, input ready);
  modport sink (input valid, input kind, input key, input data, output ready);
endinterface

interface lht_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [lht_pkg::STATUS_W-1:0] status;
  logic [lht_pkg::DATA_W-1:0]   result_data;
  modport source (output valid, output status, output result_data, input ready);
  modport sink (input valid, input status, input result_data, output ready);
endinterface

interface lht_cfg_if;
  logic                     valid;
  logic                     ready;
  logic [lht_pkg::LL_W-1:0] load_limit;
  modport source (output valid, output load_limit, input ready);
  modport sink (input valid, input load_limit, output ready);
endinterface
`default_nettype wire

FILE: hdl/lht_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lht_dp: linear hash table datapath
// Bucket head memory, entry key/value/link memories, table geometry and
// pool registers, chain walk and split registers, result registers.
// ----------------------------------------------------------------------------
module lht_dp #(
  parameter int MIN_BUCKETS  = 1024,
  parameter int MAX_BUCKETS  = 4096,
  parameter int POOL_ENTRIES = 16384,
  parameter int KEY_SHIFT    = 3
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire lht_pkg::cmd_t           cmd_i,
  output lht_pkg::sts_t                sts_o,
  input  wire [lht_pkg::KIND_W-1:0]    req_kind_i,
  input  wire [lht_pkg::KEY_W-1:0]     req_key_i,
  input  wire [lht_pkg::DATA_W-1:0]    req_data_i,
  input  wire                          cfg_we_i,
  input  wire [lht_pkg::LL_W-1:0]      cfg_data_i,
  output logic [lht_pkg::STATUS_W-1:0] rsp_status_o,
  output logic [lht_pkg::DATA_W-1:0]   rsp_data_o
);

  localparam int PW  = $clog2(POOL_ENTRIES + 1);
  localparam int PIW = $clog2(POOL_ENTRIES);
  localparam int BIW = $clog2(MAX_BUCKETS);
  localparam int SW  = BIW + 1;
  localparam int TW  = (PW + 1 > lht_pkg::LL_W + SW) ? PW + 1 : lht_pkg::LL_W + SW;
  localparam logic [PW-1:0] NIL = PW'(POOL_ENTRIES);

  logic [PW-1:0]  heads_mem [MAX_BUCKETS];
  logic [lht_pkg::KEY_W-1:0]  keys_mem [POOL_ENTRIES];
  logic [lht_pkg::DATA_W-1:0] vals_mem [POOL_ENTRIES];
  logic [PW-1:0]  links_mem [POOL_ENTRIES];

  logic [lht_pkg::KIND_W-1:0]   kind_q;
  logic [lht_pkg::KEY_W-1:0]    key_q;
  logic [lht_pkg::DATA_W-1:0]   data_q;
  logic [lht_pkg::LL_W-1:0]     ll_q;
  logic [PW-1:0]  free_q, nu_q, kc_q, cur_q, prev_q, cell_q, old_l_q, new_l_q;
  logic [BIW-1:0] sp_q, bidx_q, old_b_q, new_b_q, clr_q;
  logic [SW-1:0]  small_q, bc_q;
  logic [lht_pkg::STATUS_W-1:0] res_st_q;
  logic [lht_pkg::DATA_W-1:0]   res_dt_q;

  logic [PW-1:0]  head_rd_q, link_rd_q;
  logic [lht_pkg::KEY_W-1:0]  key_rd_q;
  logic [lht_pkg::DATA_W-1:0] val_rd_q;

  logic           head_we, link_we, kv_we;
  logic [BIW-1:0] head_ra, head_wa, bq;
  logic [PW-1:0]  head_wd, link_wd;
  logic [PIW-1:0] ent_ra, link_wa;
  logic           to_new;
  logic [TW-1:0]  thr, kc_next;
  logic [SW:0]    reach;
  logic [SW-1:0]  sp_inc;

  function automatic logic [BIW-1:0] bucket_of(input logic [lht_pkg::KEY_W-1:0] k,
                                               input logic [BIW-1:0] sp,
                                               input logic [SW-1:0] small_sz);
    logic [SW-1:0] kk;
    logic [SW-1:0] b;
    logic [SW-1:0] mask_l;
    kk     = SW'(k >> KEY_SHIFT);
    mask_l = SW'({small_sz, 1'b0} - (SW + 1)'(1));
    b      = kk & (small_sz - SW'(1));
    if ({1'b0, b} < (SW + 1)'(sp)) begin
      b = kk & mask_l;
    end
    if ({1'b0, b} >= (SW + 1)'(MAX_BUCKETS)) begin
      b = SW'({1'b0, b} - (SW + 1)'(MAX_BUCKETS));
    end
    return BIW'(b);
  endfunction

  assign bq      = bucket_of(key_q, sp_q, small_q);
  assign to_new  = (bucket_of(key_rd_q, sp_q, small_q) == new_b_q);
  assign thr     = TW'(ll_q) * TW'(bc_q);
  assign kc_next = TW'(kc_q) + TW'(1);
  assign reach   = (SW + 1)'(sp_q) + (SW + 1)'(small_q);
  assign sp_inc  = SW'(sp_q) + SW'(1);

  always_comb begin
    sts_o.kind       = kind_q;
    sts_o.cur_nil    = (cur_q >= NIL);
    sts_o.lk_hit     = (key_rd_q == key_q);
    sts_o.rm_hit     = (key_rd_q == key_q) &&
                       ((data_q == '0) || (val_rd_q == data_q));
    sts_o.free_avail = (free_q < NIL);
    sts_o.pool_full  = (free_q >= NIL) && (nu_q >= NIL);
    sts_o.split_go   = (kc_next >= thr) && (reach < (SW + 1)'(MAX_BUCKETS));
    sts_o.clr_done   = (clr_q == BIW'(MAX_BUCKETS - 1));
  end

  always_comb begin
    head_ra = bq;
    head_we = 1'b0;
    head_wa = bidx_q;
    head_wd = NIL;
    ent_ra  = cur_q[PIW-1:0];
    link_we = 1'b0;
    link_wa = cur_q[PIW-1:0];
    link_wd = NIL;
    kv_we   = 1'b0;
    unique case (cmd_i.op)
      lht_pkg::OP_CLEAR: begin
        head_we = 1'b1;
        head_wa = clr_q;
      end
      lht_pkg::OP_SP_START: head_ra = sp_q;
      lht_pkg::OP_SP_CMP: begin
        link_we = 1'b1;
        link_wd = to_new ? new_l_q : old_l_q;
      end
      lht_pkg::OP_SP_WR_OLD: begin
        head_we = 1'b1;
        head_wa = old_b_q;
        head_wd = old_l_q;
      end
      lht_pkg::OP_SP_WR_NEW: begin
        head_we = 1'b1;
        head_wa = new_b_q;
        head_wd = new_l_q;
      end
      lht_pkg::OP_ALLOC: ent_ra = free_q[PIW-1:0];
      lht_pkg::OP_INS_LINK: begin
        kv_we   = 1'b1;
        link_we = 1'b1;
        link_wa = cell_q[PIW-1:0];
        link_wd = head_rd_q;
        head_we = 1'b1;
        head_wd = cell_q;
      end
      lht_pkg::OP_RM_CMP: begin
        if (sts_o.rm_hit) begin
          // unlink: chain head or predecessor link takes the successor
          if (prev_q >= NIL) begin
            head_we = 1'b1;
            head_wd = link_rd_q;
          end else begin
            link_we = 1'b1;
            link_wa = prev_q[PIW-1:0];
            link_wd = link_rd_q;
          end
        end
      end
      lht_pkg::OP_RM_FREE: begin
        link_we = 1'b1;
        link_wa = cell_q[PIW-1:0];
        link_wd = free_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (head_we) begin
      heads_mem[head_wa] <= head_wd;
    end
    head_rd_q <= heads_mem[head_ra];
  end

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      links_mem[link_wa] <= link_wd;
    end
    link_rd_q <= links_mem[ent_ra];
  end

  always_ff @(posedge clk_i) begin
    if (kv_we) begin
      keys_mem[cell_q[PIW-1:0]] <= key_q;
      vals_mem[cell_q[PIW-1:0]] <= data_q;
    end
    key_rd_q <= keys_mem[ent_ra];
    val_rd_q <= vals_mem[ent_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ll_q    <= lht_pkg::LL_RESET;
      free_q  <= NIL;
      nu_q    <= '0;
      sp_q    <= '0;
      small_q <= SW'(MIN_BUCKETS);
      kc_q    <= '0;
      bc_q    <= SW'(MIN_BUCKETS);
      clr_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        ll_q <= cfg_data_i;
      end
      case (cmd_i.op)
        lht_pkg::OP_CLEAR: clr_q <= clr_q + BIW'(1);
        lht_pkg::OP_INS: begin
          if (!sts_o.pool_full) begin
            kc_q <= kc_q + PW'(1);
          end
        end
        lht_pkg::OP_SP_START: begin
          if (sp_inc == small_q) begin
            sp_q    <= '0;
            small_q <= {small_q[SW-2:0], 1'b0};
          end else begin
            sp_q <= BIW'(sp_inc);
          end
          bc_q <= bc_q + SW'(1);
        end
        lht_pkg::OP_ALLOC: begin
          if (!sts_o.free_avail) begin
            nu_q <= nu_q + PW'(1);
          end
        end
        lht_pkg::OP_ALLOC_W: free_q <= link_rd_q;
        lht_pkg::OP_RM_CMP: begin
          if (sts_o.rm_hit) begin
            kc_q <= kc_q - PW'(1);
          end
        end
        lht_pkg::OP_RM_FREE: free_q <= cell_q;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_acc) begin
      kind_q   <= req_kind_i;
      key_q    <= req_key_i;
      data_q   <= req_data_i;
      res_st_q <= lht_pkg::ST_MISS;
      res_dt_q <= '0;
    end
    if (cmd_i.out_load) begin
      rsp_status_o <= res_st_q;
      rsp_data_o   <= res_dt_q;
    end
    case (cmd_i.op)
      lht_pkg::OP_HEAD: bidx_q <= bq;
      lht_pkg::OP_HEADW: begin
        cur_q  <= head_rd_q;
        prev_q <= NIL;
      end
      lht_pkg::OP_LK_CMP: begin
        if (sts_o.lk_hit) begin
          res_st_q <= lht_pkg::ST_OK;
          res_dt_q <= val_rd_q;
        end else begin
          cur_q <= link_rd_q;
        end
      end
      lht_pkg::OP_INS: begin
        if (sts_o.pool_full) begin
          res_st_q <= lht_pkg::ST_FULL;
        end
      end
      lht_pkg::OP_SP_START: begin
        old_b_q <= sp_q;
        new_b_q <= BIW'(reach);
        old_l_q <= NIL;
        new_l_q <= NIL;
      end
      lht_pkg::OP_SP_HEADW: cur_q <= head_rd_q;
      lht_pkg::OP_SP_CMP: begin
        if (to_new) begin
          new_l_q <= cur_q;
        end else begin
          old_l_q <= cur_q;
        end
        cur_q <= link_rd_q;
      end
      lht_pkg::OP_ALLOC: cell_q <= sts_o.free_avail ? free_q : nu_q;
      lht_pkg::OP_INS_HEAD: bidx_q <= bq;
      lht_pkg::OP_INS_LINK: res_st_q <= lht_pkg::ST_OK;
      lht_pkg::OP_RM_CMP: begin
        if (sts_o.rm_hit) begin
          res_st_q <= lht_pkg::ST_OK;
          res_dt_q <= val_rd_q;
          cell_q   <= cur_q;
        end else begin
          prev_q <= cur_q;
          cur_q  <= link_rd_q;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

FILE: hdl/lht_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lht_ctrl: linear hash table controller
// Sequences head clearing, chain walks, bucket splits and allocation, and
// owns the request and response handshakes.
// ----------------------------------------------------------------------------
module lht_ctrl (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                req_valid_i,
  output logic               req_ready_o,
  output logic               rsp_valid_o,
  input  wire                rsp_ready_i,
  input  wire lht_pkg::sts_t sts_i,
  output lht_pkg::cmd_t      cmd_o
);

  logic [lht_pkg::OP_W-1:0] state_q, state_d;
  logic                     out_valid_q, out_valid_d;
  logic                     out_load;

  assign req_ready_o = (state_q == lht_pkg::OP_IDLE);
  assign rsp_valid_o = out_valid_q;
  assign out_load    = (state_q == lht_pkg::OP_FIN) && (!out_valid_q || rsp_ready_i);

  assign cmd_o.op       = state_q;
  assign cmd_o.in_acc   = req_valid_i && req_ready_o;
  assign cmd_o.out_load = out_load;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lht_pkg::OP_CLEAR:    if (sts_i.clr_done) state_d = lht_pkg::OP_IDLE;
      lht_pkg::OP_IDLE:     if (req_valid_i) state_d = lht_pkg::OP_DISPATCH;
      lht_pkg::OP_DISPATCH: begin
        unique case (sts_i.kind) inside
          lht_pkg::KIND_LOOKUP, lht_pkg::KIND_REMOVE: state_d = lht_pkg::OP_HEAD;
          lht_pkg::KIND_INSERT: state_d = lht_pkg::OP_INS;
          default: state_d = lht_pkg::OP_FIN;
        endcase
      end
      lht_pkg::OP_HEAD:     state_d = lht_pkg::OP_HEADW;
      lht_pkg::OP_HEADW:    state_d = (sts_i.kind == lht_pkg::KIND_REMOVE) ?
                                      lht_pkg::OP_RM_RD : lht_pkg::OP_LK_RD;
      lht_pkg::OP_LK_RD:    state_d = sts_i.cur_nil ? lht_pkg::OP_FIN : lht_pkg::OP_LK_CMP;
      lht_pkg::OP_LK_CMP:   state_d = sts_i.lk_hit ? lht_pkg::OP_FIN : lht_pkg::OP_LK_RD;
      lht_pkg::OP_INS: begin
        if (sts_i.pool_full) begin
          state_d = lht_pkg::OP_FIN;
        end else if (sts_i.split_go) begin
          state_d = lht_pkg::OP_SP_START;
        end else begin
          state_d = lht_pkg::OP_ALLOC;
        end
      end
      lht_pkg::OP_SP_START:  state_d = lht_pkg::OP_SP_HEADW;
      lht_pkg::OP_SP_HEADW:  state_d = lht_pkg::OP_SP_RD;
      lht_pkg::OP_SP_RD:     state_d = sts_i.cur_nil ? lht_pkg::OP_SP_WR_OLD : lht_pkg::OP_SP_CMP;
      lht_pkg::OP_SP_CMP:    state_d = lht_pkg::OP_SP_RD;
      lht_pkg::OP_SP_WR_OLD: state_d = lht_pkg::OP_SP_WR_NEW;
      lht_pkg::OP_SP_WR_NEW: state_d = lht_pkg::OP_ALLOC;
      lht_pkg::OP_ALLOC:     state_d = sts_i.free_avail ? lht_pkg::OP_ALLOC_W :
                                       lht_pkg::OP_INS_HEAD;
      lht_pkg::OP_ALLOC_W:   state_d = lht_pkg::OP_INS_HEAD;
      lht_pkg::OP_INS_HEAD:  state_d = lht_pkg::OP_INS_LINK;
      lht_pkg::OP_INS_LINK:  state_d = lht_pkg::OP_FIN;
      lht_pkg::OP_RM_RD:     state_d = sts_i.cur_nil ? lht_pkg::OP_FIN : lht_pkg::OP_RM_CMP;
      lht_pkg::OP_RM_CMP:    state_d = sts_i.rm_hit ? lht_pkg::OP_RM_FREE : lht_pkg::OP_RM_RD;
      lht_pkg::OP_RM_FREE:   state_d = lht_pkg::OP_FIN;
      // hold until the response slot frees up
      lht_pkg::OP_FIN:       if (out_load) state_d = lht_pkg::OP_IDLE;
      default:               state_d = lht_pkg::OP_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lht_pkg::OP_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTHESIS
  a_fin_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lht_pkg::OP_FIN) && out_valid_q && !rsp_ready_i |=>
      (state_q == lht_pkg::OP_FIN))
    else $error("result overwrote a pending response");
  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q)
    else $error("response load did not raise valid");
  a_split_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lht_pkg::OP_SP_RD) && sts_i.cur_nil |=>
      (state_q == lht_pkg::OP_SP_WR_OLD))
    else $error("split walk did not finish at chain end");
`endif

endmodule
`default_nettype wire

FILE: hdl/linear_hash_table.sv
`timescale 1ns / 1ps
`default_nettype none
// Lookup and remove walk the chain of their bucket entry by entry; an insert
// allocates a cell, first splitting one bucket's chain when the key count
// reaches the load limit times the bucket count (pool full: status FULL).
// Throughput: one request at a time, bounded by the serial chain walk
// through the registered entry memories.
// Reset: a clearing pass writes every bucket head before requests are taken.
// ----------------------------------------------------------------------------
// linear_hash_table: chained linear hash table, top level
// Connects the controller and datapath to the request, response and
// configuration channels.
// ----------------------------------------------------------------------------
module linear_hash_table #(
  parameter int MIN_BUCKETS  = 1024,
  parameter int MAX_BUCKETS  = 4096,
  parameter int POOL_ENTRIES = 16384,
  parameter int KEY_SHIFT    = 3
) (
  input  wire     clk_i,
  input  wire     rst_ni,
  lht_req_if.sink   req_i,
  lht_cfg_if.sink   cfg_i,
  lht_rsp_if.source rsp_o
);

  lht_pkg::cmd_t cmd;
  lht_pkg::sts_t sts;

  assign cfg_i.ready = 1'b1;

  lht_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lht_dp #(
    .MIN_BUCKETS  (MIN_BUCKETS),
    .MAX_BUCKETS  (MAX_BUCKETS),
    .POOL_ENTRIES (POOL_ENTRIES),
    .KEY_SHIFT    (KEY_SHIFT)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .req_kind_i   (req_i.kind),
    .req_key_i    (req_i.key),
    .req_data_i   (req_i.data),
    .cfg_we_i     (cfg_i.valid),
    .cfg_data_i   (cfg_i.load_limit),
    .rsp_status_o (rsp_o.status),
    .rsp_data_o   (rsp_o.result_data)
  );

endmodule
`default_nettype wire

FILE: sim/tb_linear_hash_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_linear_hash_table: self-checking bench for the linear hash table
// Drives lookup, insert, remove and unused-kind requests with random gaps and response
// stalls, keeps its own copy of the table to predict each result and
// compares every response field by field. Covers load limit extremes,
// bucket splits and cell recycling.
// ----------------------------------------------------------------------------

class lht_scoreboard;
  localparam int unsigned NBUCK = 4096;
  localparam int unsigned NPOOL = 16384;
  localparam int unsigned MINB  = 1024;
  localparam int unsigned NIL   = NPOOL;

  int unsigned      heads [NBUCK];
  bit [63:0]        keys  [NPOOL];
  bit [63:0]        vals  [NPOOL];
  int unsigned      links [NPOOL];
  int unsigned      free_head, fresh_cnt, split_ptr, small_sz, key_cnt, buck_cnt;
  int unsigned      load_limit;
  int               mismatches;
  logic [lht_pkg::STATUS_W-1:0] exp_status [$];
  logic [lht_pkg::DATA_W-1:0]   exp_data [$];

  function new();
    foreach (heads[i]) heads[i] = NIL;
    foreach (links[i]) links[i] = NIL;
    free_head = NIL;
    fresh_cnt = 0;
    split_ptr = 0;
    small_sz = MINB;
    key_cnt = 0;
    buck_cnt = MINB;
    load_limit = lht_pkg::LL_RESET;
    mismatches = 0;
  endfunction

  function int unsigned bucket_of(bit [63:0] key);
    bit [63:0] k;
    bit [63:0] b;
    k = key >> 3;
    b = k & 64'(small_sz - 1);
    if (b < split_ptr) b = k & 64'(2 * small_sz - 1);
    return int'(b % NBUCK);
  endfunction

  function void split_bucket();
    int unsigned old_b, new_b, cur, nxt, old_list, new_list;
    if (split_ptr + small_sz >= NBUCK) return;
    old_b = split_ptr;
    new_b = small_sz + split_ptr;
    split_ptr++;
    if (split_ptr == small_sz) begin
      split_ptr = 0;
      small_sz *= 2;
    end
    buck_cnt++;
    old_list = NIL;
    new_list = NIL;
    cur = heads[old_b];
    while (cur < NIL) begin
      nxt = links[cur];
      if (bucket_of(keys[cur]) == new_b) begin
        links[cur] = new_list;
        new_list = cur;
      end else begin
        links[cur] = old_list;
        old_list = cur;
      end
      cur = nxt;
    end
    heads[old_b] = old_list;
    heads[new_b] = new_list;
  endfunction

  // Predict the result of an accepted request and queue it.
  function void note_request(logic [lht_pkg::KIND_W-1:0] kind, bit [63:0] key,
                             bit [63:0] data);
    logic [lht_pkg::STATUS_W-1:0] st;
    bit [63:0] rd;
    int unsigned cur, prev, slot, b;
    st = lht_pkg::ST_MISS;
    rd = '0;
    if (kind == lht_pkg::KIND_LOOKUP) begin
      cur = heads[bucket_of(key)];
      while (cur < NIL) begin
        if (keys[cur] == key) begin
          st = lht_pkg::ST_OK;
          rd = vals[cur];
          break;
        end
        cur = links[cur];
      end
    end else if (kind == lht_pkg::KIND_INSERT) begin
      if (free_head >= NIL && fresh_cnt >= NPOOL) begin
        st = lht_pkg::ST_FULL;
      end else begin
        key_cnt++;
        if (key_cnt >= load_limit * buck_cnt) split_bucket();
        if (free_head < NIL) begin
          slot = free_head;
          free_head = links[slot];
        end else begin
          slot = fresh_cnt;
          fresh_cnt++;
        end
        b = bucket_of(key);
        keys[slot] = key;
        vals[slot] = data;
        links[slot] = heads[b];
        heads[b] = slot;
        st = lht_pkg::ST_OK;
      end
    end else if (kind == lht_pkg::KIND_REMOVE) begin
      b = bucket_of(key);
      cur = heads[b];
      prev = NIL;
      while (cur < NIL) begin
        if (keys[cur] == key && (data == 0 || vals[cur] == data)) begin
          if (prev >= NIL) heads[b] = links[cur];
          else links[prev] = links[cur];
          key_cnt--;
          rd = vals[cur];
          st = lht_pkg::ST_OK;
          links[cur] = free_head;
          free_head = cur;
          break;
        end
        prev = cur;
        cur = links[cur];
      end
    end
    exp_status.push_back(st);
    exp_data.push_back(rd);
  endfunction

  function void check_response(logic [lht_pkg::STATUS_W-1:0] st,
                               logic [lht_pkg::DATA_W-1:0] rd);
    logic [lht_pkg::STATUS_W-1:0] es;
    logic [lht_pkg::DATA_W-1:0] ed;
    if (exp_status.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected response: status %0d data %h", st, rd);
      return;
    end
    es = exp_status.pop_front();
    ed = exp_data.pop_front();
    if (st !== es || rd !== ed) begin
      mismatches++;
      if (mismatches <= 10)
        $display("response mismatch: status exp %0d got %0d, data exp %h got %h",
                 es, st, ed, rd);
    end
  endfunction

  function int pending();
    return exp_status.size();
  endfunction
endclass

module tb_linear_hash_table;
  localparam logic [lht_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 60000;
  localparam int NKEYS = 48;

  logic clk;
  logic rst_n;
  lht_req_if req ();
  lht_rsp_if rsp ();
  lht_cfg_if cfg ();

  lht_scoreboard table_sb;
  bit [63:0] key_pool [NKEYS];
  bit [63:0] last_data [NKEYS];
  bit no_idle;
  bit stall_off;
  int stall_hold;
  int idle_cycles;

  linear_hash_table dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req),
    .cfg_i (cfg),
    .rsp_o (rsp)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Response side: random stalls.
  always @(negedge clk) begin
    if (!rst_n) begin
      rsp.ready <= 1'b0;
    end else if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= 1'b1;
      if (!stall_off && $urandom_range(0, 3) == 0) stall_hold <= pick_gap();
    end
  end

  // Monitor and watchdog.
  always @(posedge clk) begin
    if (rst_n) begin
      if (req.valid && req.ready) table_sb.note_request(req.kind, req.key, req.data);
      if (rsp.valid && rsp.ready) table_sb.check_response(rsp.status, rsp.result_data);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles > IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic send(logic [lht_pkg::KIND_W-1:0] kind, bit [63:0] key, bit [63:0] data);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk) req.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req.valid <= 1'b1;
    req.kind <= kind;
    req.key <= key;
    req.data <= data;
    do @(posedge clk); while (!req.ready);
  endtask

  task automatic drain();
    @(negedge clk) req.valid <= 1'b0;
    while (table_sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_limit(logic [lht_pkg::LL_W-1:0] value);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.load_limit <= value;
    do @(posedge clk); while (!cfg.ready);
    table_sb.load_limit = value;
    @(negedge clk) cfg.valid <= 1'b0;
  endtask

  function bit [63:0] pick_data();
    if ($urandom_range(0, 9) == 0) return '0;
    return {$urandom, $urandom};
  endfunction

  task automatic random_phase(int count);
    int i, idx, r;
    bit [63:0] d;
    for (i = 0; i < count; i++) begin
      idx = $urandom_range(0, NKEYS - 1);
      r = $urandom_range(0, 99);
      if (r < 35) begin
        send(lht_pkg::KIND_LOOKUP,
             ($urandom_range(0, 9) == 0) ? {$urandom, $urandom} : key_pool[idx],
             {$urandom, $urandom});
      end else if (r < 70) begin
        d = pick_data();
        last_data[idx] = d;
        send(lht_pkg::KIND_INSERT, key_pool[idx], d);
      end else if (r < 97) begin
        r = $urandom_range(0, 9);
        d = (r < 4) ? 64'd0 : (r < 8) ? last_data[idx] : {$urandom, $urandom};
        send(lht_pkg::KIND_REMOVE, key_pool[idx], d);
      end else begin
        send(KIND_UNUSED, key_pool[idx], {$urandom, $urandom});
      end
    end
  endtask

  initial begin
    bit [11:0] bsel [5];
    int i;
    bit [63:0] k;
    table_sb = new();
    rst_n = 1'b0;
    req.valid = 1'b0;
    req.kind = lht_pkg::KIND_LOOKUP;
    req.key = '0;
    req.data = '0;
    cfg.valid = 1'b0;
    cfg.load_limit = lht_pkg::LL_RESET;
    rsp.ready = 1'b0;
    no_idle = 1'b0;
    stall_off = 1'b0;
    stall_hold = 0;
    idle_cycles = 0;
    // A few buckets that alias until splits separate them.
    bsel = '{12'd0, 12'd1, 12'd1024, 12'd2049, 12'd3072};
    foreach (key_pool[j]) begin
      k = {$urandom, $urandom};
      k[14:3] = bsel[$urandom_range(0, 4)];
      key_pool[j] = k;
      last_data[j] = '0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed: every insert tries to split.
    write_limit(4'd0);
    send(lht_pkg::KIND_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
    send(lht_pkg::KIND_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send(lht_pkg::KIND_INSERT, 64'd0, 64'd0);
    send(lht_pkg::KIND_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
    send(lht_pkg::KIND_LOOKUP, 64'd0, 64'h1);
    send(lht_pkg::KIND_INSERT, key_pool[0], 64'hAAAA_5555_AAAA_5555);
    send(lht_pkg::KIND_INSERT, key_pool[0], 64'h5555_AAAA_5555_AAAA);
    send(lht_pkg::KIND_LOOKUP, key_pool[0], 64'd0);
    send(lht_pkg::KIND_REMOVE, key_pool[0], 64'h1234);
    send(lht_pkg::KIND_REMOVE, key_pool[0], 64'hAAAA_5555_AAAA_5555);
    send(lht_pkg::KIND_LOOKUP, key_pool[0], 64'd0);
    send(lht_pkg::KIND_REMOVE, key_pool[0], 64'd0);
    send(lht_pkg::KIND_REMOVE, key_pool[0], 64'd0);
    send(lht_pkg::KIND_INSERT, key_pool[1], 64'h77);
    send(KIND_UNUSED, key_pool[1], 64'h77);
    send(lht_pkg::KIND_LOOKUP, key_pool[1], 64'd0);
    send(lht_pkg::KIND_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
    send(lht_pkg::KIND_REMOVE, 64'd0, 64'd0);
    drain();

    write_limit(4'd15);
    random_phase(180);
    drain();
    write_limit(4'd1);
    random_phase(180);
    drain();
    write_limit(4'd0);
    random_phase(180);
    drain();
    write_limit(4'(5 + $urandom_range(0, 9)));
    stall_off = 1'b1;
    no_idle = 1'b1;
    random_phase(100);
    stall_off = 1'b0;
    no_idle = 1'b0;
    random_phase(100);
    drain();

    // Recycle cells through the free list with mixed traffic.
    write_limit(4'd1);
    for (i = 0; i < 60; i++) begin
      send(lht_pkg::KIND_REMOVE, key_pool[$urandom_range(0, NKEYS - 1)], 64'd0);
      send(lht_pkg::KIND_INSERT, key_pool[$urandom_range(0, NKEYS - 1)], pick_data());
      send(lht_pkg::KIND_LOOKUP, key_pool[$urandom_range(0, NKEYS - 1)], 64'd0);
    end
    drain();

    if (table_sb.mismatches == 0 && table_sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

FILE: files.f
hdl/lht_pkg.sv
hdl/lht_if.sv
hdl/lht_dp.sv
hdl/lht_ctrl.sv
hdl/linear_hash_table.sv
sim/tb_linear_hash_table.sv
